>>> rtl/core/error_diffusion_dither_macros.svh
// assertion helpers used by the dither core back end
`ifndef ERROR_DIFFUSION_DITHER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define EDD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/edd_pkg.sv
package edd_pkg;

  localparam int GrayW      = 8;
  localparam int ErrW       = 10;
  localparam int SumW       = 11;
  localparam int LineWidthW = 11;
  localparam int CfgIdxW    = 1;

  typedef logic [GrayW-1:0]        gray_t;
  typedef logic signed [ErrW-1:0]  err_t;

  // per-pixel classification handed from front to back
  typedef struct packed {
    logic first;    // first pixel of a frame
    logic last;     // last pixel of its row
    logic clamped;  // column ran past a lowered line width
  } pix_flags_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxLineWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxFourLevel = 1'b1;
  localparam logic [LineWidthW-1:0] LineWidthReset = 11'd128;

  // luma weights, sum scaled by 32
  localparam int WtRed     = 11;
  localparam int WtGreen   = 16;
  localparam int WtBlue    = 5;
  localparam int GrayShift = 5;

  // quantizer thresholds and levels
  localparam logic [7:0] ThreshTwo = 8'd128;
  localparam logic [7:0] ThreshLo  = 8'(85 - 42);
  localparam logic [7:0] ThreshMid = 8'(170 - 42);
  localparam logic [7:0] ThreshHi  = 8'(255 - 42);
  localparam logic [7:0] LevelOne  = 8'd85;
  localparam logic [7:0] LevelTwo  = 8'd170;
  localparam logic [7:0] LevelMax  = 8'd255;

  // error shares in sixteenths
  localparam int ShareRight      = 7;
  localparam int ShareBelowLeft  = 3;
  localparam int ShareBelow      = 5;
  localparam int ShareBelowRight = 1;

endpackage

>>> rtl/core/edd_ram.sv
module edd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/edd_front.sv
module edd_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  input  logic                                 frame_start,
  input  logic [edd_pkg::LineWidthW-1:0]       line_width,
  input  logic                                 room,
  output logic                                 push,
  output edd_pkg::gray_t                       gray,
  output logic [$clog2(MAX_WIDTH)-1:0]         col,
  output edd_pkg::pix_flags_t                  flags
);

  import edd_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (CntW > LineWidthW) ? CntW : LineWidthW;

  logic [CmpW-1:0] lw_ext;
  logic [CmpW-1:0] w_eff;
  logic [ColW-1:0] w_m1;
  logic [ColW-1:0] column;
  logic [ColW-1:0] col_next;
  logic            clamped;
  logic            last;
  logic [12:0]     wsum;

  assign in_ready = room;
  assign push     = in_valid && room;

  // saturate the line width to 2..MAX_WIDTH
  always_comb begin
    lw_ext = CmpW'(line_width);
    if (lw_ext < CmpW'(2)) begin
      w_eff = CmpW'(2);
    end else if (lw_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    w_m1 = ColW'(w_eff - CmpW'(1));
  end

  always_comb begin
    clamped = !frame_start && (CmpW'(column) >= w_eff);
    if (frame_start) begin
      col = '0;
    end else if (clamped) begin
      col = w_m1;
    end else begin
      col = column;
    end
    last     = (col == w_m1);
    col_next = last ? '0 : ColW'(col + ColW'(1));
  end

  assign wsum = 13'(WtRed) * 13'(red) + 13'(WtGreen) * 13'(green) + 13'(WtBlue) * 13'(blue);
  assign gray = wsum[GrayShift +: GrayW];

  assign flags.first   = frame_start;
  assign flags.last    = last;
  assign flags.clamped = clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (push) begin
      column <= col_next;
    end
  end

endmodule

>>> rtl/core/edd_queue.sv
module edd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int Depth = 4;
  localparam int PtrW  = 2;
  localparam int CntW  = 3;

  logic [WIDTH-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(Depth));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/core/edd_back.sv
`include "error_diffusion_dither_macros.svh"

module edd_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         four_level,
  input  logic                         in_valid,
  output logic                         in_pop,
  input  edd_pkg::gray_t               in_gray,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  edd_pkg::pix_flags_t          in_flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_level,
  output logic                         out_last
);

  import edd_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = $clog2(MAX_WIDTH + 1);

  function automatic logic [7:0] quantize(input logic [7:0] v, input logic four);
    logic [7:0] q;
    if (!four) begin
      q = (v < ThreshTwo) ? '0 : LevelMax;
    end else if (v < ThreshLo) begin
      q = '0;
    end else if (v < ThreshMid) begin
      q = LevelOne;
    end else if (v < ThreshHi) begin
      q = LevelTwo;
    end else begin
      q = LevelMax;
    end
    return q;
  endfunction

  // (e * w) / 16 truncated toward zero
  function automatic logic signed [7:0] share16(input logic signed [8:0] e,
                                                input logic [2:0] w);
    logic signed [12:0] p;
    logic signed [12:0] r;
    p = e * $signed({1'b0, w});
    if (p[12]) begin
      p = p + 13'sd15;
    end
    r = p >>> 4;
    return r[7:0];
  endfunction

  // compute stage
  logic              b1_valid;
  gray_t             b1_gray;
  logic [ColW-1:0]   b1_col;
  pix_flags_t        b1_flags;
  logic              fwd_hit;
  err_t              fwd_val;

  // error state
  err_t              held_val;
  logic [ColW-1:0]   held_addr;
  logic              held_valid;
  logic signed [7:0] right_carry;
  logic signed [7:0] below_right;
  logic [CntW-1:0]   fill;
  logic              phase_b;
  err_t              saved_nre;

  logic              out_valid_r;
  logic [7:0]        out_level_r;
  logic              out_last_r;

  logic              ram_we;
  logic [ColW-1:0]   ram_waddr;
  err_t              ram_wdata;
  logic              ram_re;
  logic [ColW-1:0]   ram_raddr;
  err_t              ram_rdata;

  logic              phase_a;
  logic              b1_fire;
  logic [ColW-1:0]   col_m1;
  err_t              nre_res;
  err_t              nre;
  logic signed [7:0] rc;
  logic signed [7:0] pbr;
  logic signed [SumW-1:0] sum;
  logic [7:0]        sat;
  logic [7:0]        level;
  logic signed [8:0] e;
  logic signed [7:0] s_right;
  logic signed [7:0] s_below_left;
  logic signed [7:0] s_below;
  logic signed [7:0] s_below_right;
  err_t              held_eff_val;
  logic [ColW-1:0]   held_eff_addr;
  logic              held_eff_ok;
  err_t              wr_val;

  // clamped pixel: first cycle flushes the held entry and fetches col-1
  assign phase_a = b1_valid && b1_flags.clamped && !phase_b;
  assign b1_fire = b1_valid && !phase_a && (!out_valid_r || out_ready);
  assign in_pop  = in_valid && (!b1_valid || b1_fire);
  assign col_m1  = b1_col - ColW'(1);

  always_comb begin
    if (held_valid && held_addr == b1_col) begin
      nre_res = held_val;
    end else if (fwd_hit) begin
      nre_res = fwd_val;
    end else if (CntW'(b1_col) < fill) begin
      nre_res = ram_rdata;
    end else begin
      nre_res = '0;
    end

    if (b1_flags.first) begin
      nre = '0;
    end else if (phase_b) begin
      nre = saved_nre;
    end else begin
      nre = nre_res;
    end
    rc  = b1_flags.first ? '0 : right_carry;
    pbr = b1_flags.first ? '0 : below_right;

    sum = $signed({{(SumW-GrayW){1'b0}}, b1_gray}) + SumW'(rc) + SumW'(nre);
    if (sum[SumW-1]) begin
      sat = '0;
    end else if (sum > SumW'(255)) begin
      sat = 8'd255;
    end else begin
      sat = sum[7:0];
    end
    level = quantize(sat, four_level);
    e     = $signed({1'b0, sat}) - $signed({1'b0, level});

    s_right       = share16(e, 3'(ShareRight));
    s_below_left  = share16(e, 3'(ShareBelowLeft));
    s_below       = share16(e, 3'(ShareBelow));
    s_below_right = share16(e, 3'(ShareBelowRight));

    if (phase_b) begin
      held_eff_val  = (CntW'(col_m1) < fill) ? ram_rdata : '0;
      held_eff_addr = col_m1;
    end else begin
      held_eff_val  = held_val;
      held_eff_addr = held_addr;
    end
    held_eff_ok = phase_b || held_valid;
    wr_val = held_eff_val + ((b1_col != '0) ? ErrW'(s_below_left) : '0);

    if (phase_a) begin
      ram_we    = held_valid;
      ram_waddr = held_addr;
      ram_wdata = held_val;
      ram_raddr = col_m1;
    end else begin
      ram_we    = b1_fire && held_eff_ok && !b1_flags.first;
      ram_waddr = held_eff_addr;
      ram_wdata = wr_val;
      ram_raddr = in_col;
    end
    ram_re = in_pop || phase_a;
  end

  edd_ram #(
    .WIDTH (ErrW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid    <= 1'b0;
      held_valid  <= 1'b0;
      right_carry <= '0;
      below_right <= '0;
      fill        <= '0;
      phase_b     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_pop) begin
        b1_valid <= 1'b1;
      end else if (b1_fire) begin
        b1_valid <= 1'b0;
      end
      if (phase_a) begin
        phase_b <= 1'b1;
      end else if (b1_fire) begin
        phase_b <= 1'b0;
      end
      if (b1_fire) begin
        held_valid  <= 1'b1;
        right_carry <= b1_flags.last ? '0 : s_right;
        below_right <= b1_flags.last ? '0 : s_below_right;
      end
      // written entries of this frame always form a prefix
      if (b1_fire && b1_flags.first) begin
        fill <= '0;
      end else if (ram_we && CntW'(ram_waddr) == fill) begin
        fill <= fill + CntW'(1);
      end
      if (b1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      b1_gray  <= in_gray;
      b1_col   <= in_col;
      b1_flags <= in_flags;
      fwd_hit  <= ram_we && (ram_waddr == in_col);
      fwd_val  <= ram_wdata;
    end
    if (phase_a) begin
      saved_nre <= nre_res;
    end
    if (b1_fire) begin
      held_val    <= ErrW'(s_below) + ErrW'(pbr);
      held_addr   <= b1_col;
      out_level_r <= level;
      out_last_r  <= b1_flags.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

  `EDD_ASSERT_IMP(a_write_in_prefix, ram_we, CntW'(ram_waddr) <= fill, "line store write past filled prefix")
  `EDD_ASSERT_IMP(a_below_left_addr, b1_fire && ram_we && (b1_col != '0), ram_waddr == col_m1, "below-left share written to wrong column")
  `EDD_ASSERT_IMP(a_clamp_stalls, phase_a, !b1_fire && !in_pop, "pixel left compute stage during flush cycle")
  `EDD_ASSERT_NXT(a_clamp_two_step, phase_a, b1_valid && phase_b, "flush cycle not followed by compute cycle")
  `EDD_ASSERT_IMP(a_fill_bound, b1_valid || !b1_valid, fill <= CntW'(MAX_WIDTH), "fill count beyond line store depth")

endmodule

>>> rtl/core/error_diffusion_dither.sv
// Error-diffusion ditherer for a raster-order RGB pixel stream. Each pixel is
// turned to gray as (11r + 16g + 5b) / 32, the error carried from its left
// neighbour and from the row above is added, the sum is clamped to 0..255 and
// quantized to 0/255 (four_level_mode = 0) or 0/85/170/255 (four_level_mode =
// 1). The quantization error is spread 7/16 right, 3/16 below-left, 5/16 below
// and 1/16 below-right, each share truncated toward zero; shares that leave the
// row are dropped. tuser high marks the first pixel of a frame; that pixel
// starts a fresh frame with zero carried error. tlast on the output marks the
// last pixel of each row. Unless the output stalls, the block sustains one
// pixel per clock; a pixel passes queue, compute stage and output register. A
// pixel whose column lies past a line width lowered mid-row costs an extra
// flush step in the back end, where the line store flushes one pending entry
// and fetches another. The line store (MAX_WIDTH x 10 bits) is not swept at
// reset or at frame start: a fill count marks the current frame's entries, so
// no clearing pass is needed. Config writes (index 0 line_width, index 1
// four_level_mode) take effect at once and are meant for idle periods.
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,

  // config write port
  input  logic                            cfg_we,
  input  logic [edd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [edd_pkg::LineWidthW-1:0]  cfg_data,

  // pixel input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                            s_axis_tuser,  // frame_start

  // dithered output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // out_level[7:0]
  output logic                            m_axis_tlast   // row_end
);

  import edd_pkg::*;

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int QWidth = $bits(pix_flags_t) + ColW + GrayW;

  // config registers
  logic [LineWidthW-1:0] line_width;
  logic                  four_level_mode;

  // front end to queue
  logic            f_push;
  gray_t           f_gray;
  logic [ColW-1:0] f_col;
  pix_flags_t      f_flags;

  // queue to back end
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [QWidth-1:0] q_rdata;
  gray_t             q_gray;
  logic [ColW-1:0]   q_col;
  pix_flags_t        q_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width      <= LineWidthReset;
      four_level_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgIdxLineWidth: line_width      <= cfg_data;
        CfgIdxFourLevel: four_level_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front end: column tracking, row end and frame start, gray conversion
  edd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .red         (s_axis_tdata[7:0]),
    .green       (s_axis_tdata[15:8]),
    .blue        (s_axis_tdata[23:16]),
    .frame_start (s_axis_tuser),
    .line_width  (line_width),
    .room        (!q_full),
    .push        (f_push),
    .gray        (f_gray),
    .col         (f_col),
    .flags       (f_flags)
  );

  // short queue so input and output stalls stay apart
  edd_queue #(
    .WIDTH (QWidth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_flags, f_col, f_gray}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign {q_flags, q_col, q_gray} = q_rdata;

  // back end: error accumulation, quantizer, line store, output register
  edd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .four_level (four_level_mode),
    .in_valid   (q_valid),
    .in_pop     (q_pop),
    .in_gray    (q_gray),
    .in_col     (q_col),
    .in_flags   (q_flags),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_level  (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MaxWidth = 1024;

  // pixel word as offered on the input stream
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  // dithered word as seen on the output stream
  typedef struct {
    logic [7:0] level;
    logic       row_end;
  } dither_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               cfg_we    = 1'b0;
  logic [edd_pkg::CfgIdxW-1:0]        cfg_index = edd_pkg::CfgIdxLineWidth;
  logic [edd_pkg::LineWidthW-1:0]     cfg_data  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        s_axis_tuser  = 1'b0; // frame_start

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // out_level[7:0]
  logic        m_axis_tlast;         // row_end

  error_diffusion_dither #(.MAX_WIDTH(MaxWidth)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pixels waiting to be offered, dithered words waiting to come out
  pixel_t       pixel_q[$];
  dither_word_t expected_levels[$];

  // dither state mirrored in the bench
  shortint          below_err[MaxWidth];  // errors stored for the next row
  int               carry_right;          // 7/16 share for the right neighbour
  int               below_right_pend;     // 1/16 share waiting for the next column
  int               col_pos;
  logic [10:0]      width_reg = edd_pkg::LineWidthReset;
  logic             four_reg  = 1'b0;

  // idling knobs, set per phase
  int src_idle_pct = 15;
  int snk_idle_pct = 15;
  logic long_hold_arm = 1'b0;

  int err_count  = 0;
  int pixels_in  = 0;
  int words_out  = 0;
  int row_ends   = 0;
  int frames     = 0;
  int settings   = 0;

  // gray conversion, error add, clamp, quantize and error spread for one pixel
  function automatic dither_word_t dither_pixel(input pixel_t p);
    dither_word_t res;
    int w, col, gray, sum, lvl, e;
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > MaxWidth) w = MaxWidth;
    if (p.frame_start) begin
      foreach (below_err[i]) below_err[i] = 0;
      carry_right      = 0;
      below_right_pend = 0;
      col_pos          = 0;
    end
    col = col_pos;
    // a column past a lowered width closes the row
    if (col >= w) col = w - 1;
    res.row_end = (col == w - 1);

    gray = (11 * int'(p.red) + 16 * int'(p.green) + 5 * int'(p.blue)) / 32;
    sum  = gray + carry_right + int'(below_err[col]);
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;

    if (!four_reg) lvl = (sum < 128) ? 0 : 255;
    else if (sum < 85 - 42) lvl = 0;
    else if (sum < 170 - 42) lvl = 85;
    else if (sum < 255 - 42) lvl = 170;
    else lvl = 255;
    e = sum - lvl;

    // shares truncate toward zero, edges drop theirs
    if (col > 0) below_err[col-1] = shortint'(int'(below_err[col-1]) + (e * 3) / 16);
    below_err[col] = shortint'((e * 5) / 16 + below_right_pend);
    if (res.row_end) begin
      carry_right      = 0;
      below_right_pend = 0;
      col_pos          = 0;
    end else begin
      carry_right      = (e * 7) / 16;
      below_right_pend = e / 16;
      col_pos          = col + 1;
    end
    res.level = 8'(lvl);
    return res;
  endfunction

  initial begin
    foreach (below_err[i]) below_err[i] = 0;
    carry_right      = 0;
    below_right_pend = 0;
    col_pos          = 0;
  end

  // source side: offers queued pixels, predicts each accepted word
  pixel_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_levels.insert(expected_levels.size(), dither_pixel(on_bus));
        pixels_in++;
        if (on_bus.frame_start) frames++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.blue, on_bus.green, on_bus.red};
          s_axis_tuser  <= on_bus.frame_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: random back-pressure, one long hold-off, compares every word
  int   hold_left      = 0;
  logic long_hold_done = 1'b0;
  always @(posedge clk) begin : sink
    dither_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (m_axis_tlast) row_ends++;
        if (expected_levels.size() == 0) begin
          err_count++;
          $display("%0t: word with nothing expected: expected none, actual level %0d row_end %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_levels.pop_front();
          if (m_axis_tdata !== want.level) begin
            err_count++;
            $display("%0t: out_level mismatch: expected %0d, actual %0d",
                     $time, want.level, m_axis_tdata);
          end
          if (m_axis_tlast !== want.row_end) begin
            err_count++;
            $display("%0t: row_end mismatch: expected %0b, actual %0b",
                     $time, want.row_end, m_axis_tlast);
          end
        end
      end
      // long stall so the block backs up and stalls its input
      if (long_hold_arm && !long_hold_done) begin
        hold_left      = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // waits until no pixel is pending and every word has come out
  task automatic wait_drained;
    do @(negedge clk);
    while (pixel_q.size() != 0 || s_axis_tvalid || expected_levels.size() != 0);
  endtask

  task automatic write_reg(input logic [edd_pkg::CfgIdxW-1:0] idx,
                           input logic [edd_pkg::LineWidthW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == edd_pkg::CfgIdxLineWidth) width_reg = val;
    else four_reg = val[0];
  endtask

  // new setting, only once the block has gone quiet
  task automatic set_mode(input logic [10:0] w, input logic four);
    wait_drained();
    write_reg(edd_pkg::CfgIdxLineWidth, w);
    write_reg(edd_pkg::CfgIdxFourLevel, edd_pkg::LineWidthW'(four));
    settings++;
  endtask

  task automatic push_rgb(input int r, input int g, input int b, input logic fs);
    pixel_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.frame_start = fs;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic logic [7:0] jitter(input int base);
    int v;
    v = base + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // random noise and smooth image content, with saturated colors and
  // grays sitting on the quantizer thresholds
  function automatic pixel_t random_pixel(input int base, input logic fs);
    pixel_t p;
    int v;
    p.frame_start = fs;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        p.red   = 8'($urandom_range(255));
        p.green = 8'($urandom_range(255));
        p.blue  = 8'($urandom_range(255));
      end
      4, 5, 6: begin
        p.red   = jitter(base);
        p.green = jitter(base);
        p.blue  = jitter(base);
      end
      7: begin
        p.red   = $urandom_range(1) ? 8'd255 : 8'd0;
        p.green = $urandom_range(1) ? 8'd255 : 8'd0;
        p.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      default: begin
        case ($urandom_range(5))
          0: v = 42;
          1: v = 43;
          2: v = 127;
          3: v = 128;
          4: v = 212;
          default: v = 213;
        endcase
        v = v + int'($urandom_range(2)) - 1;
        p.red   = 8'(v);
        p.green = 8'(v);
        p.blue  = 8'(v);
      end
    endcase
    return p;
  endfunction

  // stimulus: directed corners, then random phases, then the widest rows
  initial begin
    int          random_sent;
    int          phase_no;
    int          len;
    int          base;
    logic [10:0] w;
    logic        four;
    logic        new_frame;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset setting: 128 wide, two levels; black, white and pure primaries
    push_rgb(0, 0, 0, 1'b1);
    push_rgb(255, 255, 255, 1'b0);
    push_rgb(255, 0, 0, 1'b0);
    push_rgb(0, 255, 0, 1'b0);
    push_rgb(0, 0, 255, 1'b0);

    // four levels on short rows, grays either side of each threshold
    set_mode(11'd4, 1'b1);
    push_rgb(42, 42, 42, 1'b1);
    push_rgb(43, 43, 43, 1'b0);
    push_rgb(85, 85, 85, 1'b0);
    push_rgb(127, 127, 127, 1'b0);
    push_rgb(128, 128, 128, 1'b0);
    push_rgb(170, 170, 170, 1'b0);
    push_rgb(212, 212, 212, 1'b0);
    push_rgb(213, 213, 213, 1'b0);

    // two-level threshold, then width lowered in mid-row
    set_mode(11'd16, 1'b0);
    for (int i = 0; i < 6; i++) push_rgb(127 + (i % 2), 127 + (i % 2), 127 + (i % 2), i == 0);
    set_mode(11'd4, 1'b0);
    push_rgb(200, 90, 30, 1'b0);
    push_rgb(60, 140, 220, 1'b0);

    // widths below the minimum behave as two
    set_mode(11'd0, 1'b1);
    for (int i = 0; i < 3; i++) push_rgb(100, 100, 100, i == 0);
    set_mode(11'd1, 1'b0);
    for (int i = 0; i < 3; i++) push_rgb(90, 90, 90, 1'b0);

    // random phases: first one with no idling, a later one with the long hold-off
    random_sent = 0;
    phase_no    = 0;
    base        = 128;
    while (random_sent < 600) begin
      case ($urandom_range(5))
        0: w = 11'd2;
        1: w = 11'd3;
        2: w = 11'($urandom_range(4, 9));
        3: w = 11'($urandom_range(10, 40));
        4: w = 11'($urandom_range(41, 130));
        default: w = 11'($urandom_range(131, 400));
      endcase
      four = 1'($urandom_range(1));
      set_mode(w, four);
      if (phase_no == 0) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        len = 150;
      end else begin
        src_idle_pct = 15;
        snk_idle_pct = 15;
        len = (phase_no == 2) ? 200 : int'($urandom_range(40, 120));
      end
      new_frame = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
        base = base + int'($urandom_range(20)) - 10;
        if (base < 0) base = 0;
        if (base > 255) base = 255;
        pixel_q.insert(pixel_q.size(),
                       random_pixel(base, (i == 0 && new_frame) || $urandom_range(79) == 0));
      end
      if (phase_no == 2) long_hold_arm = 1'b1;
      random_sent += len;
      phase_no++;
    end

    // widest setting: register all ones saturates to the line store size
    set_mode(11'h7FF, 1'($urandom_range(1)));
    for (int i = 0; i < 240; i++)
      pixel_q.insert(pixel_q.size(), random_pixel(int'($urandom_range(255)), i == 0));
    set_mode(11'(MaxWidth), 1'b1);
    for (int i = 0; i < 40; i++)
      pixel_q.insert(pixel_q.size(), random_pixel(int'($urandom_range(255)), i == 0));

    wait_drained();
    repeat (16) @(posedge clk);

    if (expected_levels.size() != 0) begin
      err_count++;
      $display("%0t: words missing: expected %0d more, actual 0",
               $time, expected_levels.size());
    end
    $display("dithered %0d pixels into %0d words over %0d settings",
             pixels_in, words_out, settings);
    $display("saw %0d row ends and %0d frame starts", row_ends, frames);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("timeout with %0d words outstanding", expected_levels.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
